// ----- hdl/hsg_pkg.sv -----
// ----------------------------------------------------------------------------
// hsg_pkg
// Shared types and constants of the Halton sequence generator: the field
// widths, the prime table and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hsg_pkg;

	// Fixed field widths of the stream payloads
	localparam int FIELD_W   = 32;
	localparam int DIM_W     = 3;
	localparam int STEPS_W   = 8;
	localparam int ACTIVE_W  = 4;
	localparam int PRIME_W   = 5;
	localparam int MAX_REPORT = 8;

	// Reset value of the active dimension count
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	// Prime of each dimension
	localparam logic [PRIME_W-1:0] PRIMES [MAX_REPORT] = '{
		5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19
	};

	// Controller to datapath commands
	typedef struct packed {
		logic             restart;     // clear all dimensions to 0/1
		logic             load;        // fetch entry idx into working regs
		logic             prep;        // x = d - n, product = d * p
		logic             seed;        // t = 1, product = p
		logic             search;      // t = product, product = product * p
		logic             final_mul;   // product = t * (p + 1)
		logic             write_unit;  // entry becomes 1 / (d * p)
		logic             set_ovf;     // raise sticky overflow of entry
		logic             write_num;   // numerator = product - x
		logic             load_out;    // copy entry idx to output register
		logic             out_last;    // tlast of the loaded result
		logic [DIM_W-1:0] idx;         // dimension under work
	} hsg_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ovf;       // working entry has stopped
		logic x_one;     // d - n == 1
		logic fits;      // product fits the fraction width
		logic lt;        // product below x
		logic out_free;  // output register can take a result
	} hsg_sts_t;

endpackage

// ----- hdl/hsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsg_ctrl
// Sequencer of the Halton generator: walks steps and dimensions, drives the
// datapath through one radical-inverse step at a time, then streams out one
// result per active dimension. Holds the active dimension register.
// ----------------------------------------------------------------------------
module hsg_ctrl #(
	parameter int USED_DIMS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          in_restart,
	input  logic [hsg_pkg::STEPS_W-1:0]   in_steps,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hsg_pkg::ACTIVE_W-1:0]  cfg_data,
	output hsg_pkg::hsg_cmd_t             cmd,
	input  hsg_pkg::hsg_sts_t             sts
);
	import hsg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_PREP,
		S_DECIDE,
		S_SEARCH,
		S_WRITE,
		S_EMIT
	} state_t;

	localparam logic [ACTIVE_W-1:0] CAP = ACTIVE_W'(USED_DIMS);

	state_t              state_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [ACTIVE_W-1:0] count_q;
	logic [STEPS_W-1:0]  steps_q;
	logic [DIM_W-1:0]    idx_q;

	logic [ACTIVE_W-1:0] count_cap;
	logic                last_dim;
	logic                accept;
	logic                step_done;

	// Active count saturated to the number of built dimensions
	assign count_cap = (active_q > CAP) ? CAP : active_q;
	assign last_dim  = ({1'b0, idx_q} == (count_q - ACTIVE_W'(1)));
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// One dimension has finished its step
	assign step_done = ((state_q == S_DECIDE) && (sts.ovf || sts.x_one)) ||
		(state_q == S_WRITE);

	// Datapath commands
	always_comb begin
		cmd          = '0;
		cmd.idx      = idx_q;
		cmd.out_last = last_dim;
		unique case (state_q)
			S_IDLE: begin
				cmd.restart = accept && in_restart;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
			end
			S_DECIDE: begin
				cmd.write_unit = !sts.ovf && sts.x_one && sts.fits;
				cmd.set_ovf    = !sts.ovf && sts.x_one && !sts.fits;
				cmd.seed       = !sts.ovf && !sts.x_one;
			end
			S_SEARCH: begin
				cmd.search    = sts.lt;
				cmd.final_mul = !sts.lt;
			end
			S_WRITE: begin
				cmd.write_num = 1'b1;
			end
			S_EMIT: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= ACTIVE_RESET;
			count_q  <= '0;
			steps_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			if (step_done) begin
				if (last_dim) begin
					idx_q   <= '0;
					steps_q <= steps_q - STEPS_W'(1);
					state_q <= (steps_q == STEPS_W'(1)) ? S_EMIT : S_LOAD;
				end else begin
					idx_q   <= idx_q + DIM_W'(1);
					state_q <= S_LOAD;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							steps_q <= in_steps;
							count_q <= count_cap;
							idx_q   <= '0;
							if (count_cap == '0) begin
								state_q <= S_IDLE;
							end else if (in_steps == '0) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_LOAD;
							end
						end
					end
					S_LOAD: begin
						state_q <= S_PREP;
					end
					S_PREP: begin
						state_q <= S_DECIDE;
					end
					S_DECIDE: begin
						state_q <= S_SEARCH;
					end
					S_SEARCH: begin
						if (!sts.lt) begin
							state_q <= S_WRITE;
						end
					end
					S_WRITE: begin
						state_q <= S_LOAD;
					end
					S_EMIT: begin
						if (sts.out_free) begin
							if (last_dim) begin
								idx_q   <= '0;
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + DIM_W'(1);
							end
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// Dimension index stays inside the active range while busy
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ({1'b0, idx_q} < count_q))
		else $error("dimension index beyond active count");

	// A result is only loaded when the output register is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a pending result");

	// An accepted item with active dimensions leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (count_cap != '0)) |=> (state_q != S_IDLE))
		else $error("accepted item not started");
`endif

endmodule

// ----- hdl/hsg_dpath.sv -----
// ----------------------------------------------------------------------------
// hsg_dpath
// Datapath of the Halton generator: per-dimension fraction store, working
// registers, one shared small multiplier and the result output register.
// ----------------------------------------------------------------------------
module hsg_dpath #(
	parameter int FRAC_WIDTH = 32,
	parameter int USED_DIMS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hsg_pkg::hsg_cmd_t             cmd,
	output hsg_pkg::hsg_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hsg_pkg::DIM_W-1:0]     out_dim,
	output logic [hsg_pkg::FIELD_W-1:0]   out_num,
	output logic [hsg_pkg::FIELD_W-1:0]   out_den,
	output logic                          out_ovf,
	output logic                          out_last
);
	import hsg_pkg::*;

	localparam int IDX_W = (USED_DIMS > 1) ? $clog2(USED_DIMS) : 1;
	localparam int MUL_B = PRIME_W + 1;
	localparam int MUL_W = FRAC_WIDTH + MUL_B;

	// Fraction store
	logic [FRAC_WIDTH-1:0] num_q [USED_DIMS];
	logic [FRAC_WIDTH-1:0] den_q [USED_DIMS];
	logic                  ovf_q [USED_DIMS];

	// Working registers
	logic [FRAC_WIDTH-1:0] n_q;
	logic [FRAC_WIDTH-1:0] d_q;
	logic [FRAC_WIDTH-1:0] x_q;
	logic [FRAC_WIDTH-1:0] t_q;
	logic [PRIME_W-1:0]    p_q;
	logic                  wovf_q;
	logic [MUL_W-1:0]      mul_q;

	// Output register
	logic                  out_valid_q;
	logic [DIM_W-1:0]      out_dim_q;
	logic [FIELD_W-1:0]    out_num_q;
	logic [FIELD_W-1:0]    out_den_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	logic [IDX_W-1:0]      idx;
	logic [FRAC_WIDTH-1:0] mul_a;
	logic [MUL_B-1:0]      mul_b;
	logic [FRAC_WIDTH-1:0] new_num;

	assign idx     = cmd.idx[IDX_W-1:0];
	assign new_num = mul_q[FRAC_WIDTH-1:0] - x_q;

	// Shared multiplier operand select
	always_comb begin
		priority if (cmd.prep) begin
			mul_a = d_q;
			mul_b = {1'b0, p_q};
		end else if (cmd.seed) begin
			mul_a = FRAC_WIDTH'(1);
			mul_b = {1'b0, p_q};
		end else if (cmd.final_mul) begin
			mul_a = t_q;
			mul_b = MUL_B'(p_q) + MUL_B'(1);
		end else begin
			mul_a = mul_q[FRAC_WIDTH-1:0];
			mul_b = {1'b0, p_q};
		end
	end

	// Working registers and product
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= num_q[idx];
			d_q    <= den_q[idx];
			wovf_q <= ovf_q[idx];
			p_q    <= PRIMES[cmd.idx];
		end
		if (cmd.prep) begin
			x_q <= d_q - n_q;
		end
		if (cmd.seed) begin
			t_q <= FRAC_WIDTH'(1);
		end else if (cmd.search) begin
			t_q <= mul_q[FRAC_WIDTH-1:0];
		end
		if (cmd.prep || cmd.seed || cmd.search || cmd.final_mul) begin
			mul_q <= {{MUL_B{1'b0}}, mul_a} * {{FRAC_WIDTH{1'b0}}, mul_b};
		end
	end

	// Fraction store updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USED_DIMS; i++) begin
				num_q[i] <= '0;
				den_q[i] <= FRAC_WIDTH'(1);
				ovf_q[i] <= 1'b0;
			end
		end else if (cmd.restart) begin
			for (int i = 0; i < USED_DIMS; i++) begin
				num_q[i] <= '0;
				den_q[i] <= FRAC_WIDTH'(1);
				ovf_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.write_unit) begin
				num_q[idx] <= FRAC_WIDTH'(1);
				den_q[idx] <= mul_q[FRAC_WIDTH-1:0];
			end
			if (cmd.set_ovf) begin
				ovf_q[idx] <= 1'b1;
			end
			if (cmd.write_num) begin
				num_q[idx] <= new_num;
			end
		end
	end

	// Output register, freed when the result transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_dim_q  <= cmd.idx;
			out_num_q  <= FIELD_W'(num_q[idx]);
			out_den_q  <= FIELD_W'(den_q[idx]);
			out_ovf_q  <= ovf_q[idx];
			out_last_q <= cmd.out_last;
		end
	end

	// Status back to the controller
	assign sts.ovf      = wovf_q;
	assign sts.x_one    = (x_q == FRAC_WIDTH'(1));
	assign sts.fits     = (mul_q[MUL_W-1:FRAC_WIDTH] == '0);
	assign sts.lt       = (mul_q < {{MUL_B{1'b0}}, x_q});
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_dim   = out_dim_q;
	assign out_num   = out_num_q;
	assign out_den   = out_den_q;
	assign out_ovf   = out_ovf_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	// Restart leaves dimension zero at 0/1 and running
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> (num_q[0] == '0) && (den_q[0] == FRAC_WIDTH'(1)) && !ovf_q[0])
		else $error("restart did not clear the fraction store");

	// A new numerator stays below its denominator
	a_num_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_num |-> (new_num < d_q))
		else $error("numerator not below denominator");

	// Denominator grows whenever it is rescaled
	a_den_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_unit |-> (mul_q[FRAC_WIDTH-1:0] > d_q))
		else $error("denominator did not grow");

	// A loaded result is offered in the next cycle
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not offered");
`endif

endmodule

// ----- hdl/halton_sequence_generator_unit.sv -----
// ----------------------------------------------------------------------------
// halton_sequence_generator_unit
// Multi-dimensional Halton sequence generator with exact fractions.
//
// Input stream (s_*): one transfer carries restart and a step count. The
// block optionally clears every dimension to 0/1, steps each active dimension
// that many points, then sends one result per active dimension on the output
// stream (m_*) in order of dimension, tlast on the final one.
// Config channel (cfg_*): writes the active dimension count; the user must
// do so only while idle, the block itself does not enforce this. Each point
// of one dimension loads its entry, forms x = d - n and decides: a rescale
// or a stop ends the step there, else a power search takes k multiply
// passes (k < log_p of the denominator) before the numerator is written.
// Results go out at one per cycle while the receiver is ready.
// One item is in work at a time; s_tready is high only when idle.
// Results leave through an output register: a stalled receiver holds the
// current result and stops the next one, and the next item is accepted while
// the final result still waits. Reset clears every fraction to 0/1, drops
// all overflow flags and sets the active count to 8.
// ----------------------------------------------------------------------------
module halton_sequence_generator_unit #(
	parameter int DIMS       = 8,
	parameter int FRAC_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [0] restart, [8:1] advance_steps, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [2:0] dimension, [34:3] numerator,
	                               // [66:35] denominator, rest zero
	output logic [0:0]  m_tuser,   // [0] overflow
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // active_dimensions
);
	import hsg_pkg::*;

	localparam int USED_DIMS = (DIMS < MAX_REPORT) ? DIMS : MAX_REPORT;

	hsg_cmd_t           cmd;
	hsg_sts_t           sts;
	logic [DIM_W-1:0]   out_dim;
	logic [FIELD_W-1:0] out_num;
	logic [FIELD_W-1:0] out_den;
	logic               out_ovf;

	hsg_ctrl #(
		.USED_DIMS (USED_DIMS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.in_restart (s_tdata[0]),
		.in_steps   (s_tdata[8:1]),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts)
	);

	hsg_dpath #(
		.FRAC_WIDTH (FRAC_WIDTH),
		.USED_DIMS  (USED_DIMS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_dim   (out_dim),
		.out_num   (out_num),
		.out_den   (out_den),
		.out_ovf   (out_ovf),
		.out_last  (m_tlast)
	);

	// Result payload packing
	assign m_tdata = {5'd0, out_den, out_num, out_dim};
	assign m_tuser = out_ovf;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for halton_sequence_generator_unit. Items carrying a
// restart flag and a step count go in on the input stream. A fraction-exact
// Halton predictor works out the coordinate of each active dimension. Every
// result on the output stream is checked against the oldest expected
// coordinate. The active dimension count is rewritten between phases, and
// the sender and the receiver stall at random in several idle mixes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hsg_pkg::*;

	localparam logic [63:0] FRAC_MAX    = 64'hFFFF_FFFF;
	localparam int          HOLD_OFF    = 64;      // idle cycles before a config write
	localparam int          STALL_LIMIT = 200000;  // cycles without any transfer

	// One reported coordinate
	typedef struct packed {
		logic [DIM_W-1:0]   dim;
		logic [FIELD_W-1:0] num;
		logic [FIELD_W-1:0] den;
		logic               ovf;
		logic               last;
	} coord_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [0] restart, [8:1] advance_steps, rest zero
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [2:0] dimension, [34:3] numerator, [66:35] denominator
	logic [0:0]  m_tuser;   // [0] overflow
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;  // active_dimensions

	// Predicted fractions and configuration
	logic [FIELD_W-1:0]  frac_num  [MAX_REPORT];
	logic [FIELD_W-1:0]  frac_den  [MAX_REPORT];
	logic                frac_stop [MAX_REPORT];
	logic [ACTIVE_W-1:0] active_cfg;

	coord_t coord_q [$];

	int error_count;
	int items_sent;
	int coords_checked;
	int cfg_writes;
	int quiet_cycles;
	int src_idle_pct;
	int sink_stall_pct;

	halton_sequence_generator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: no transfer for %0d cycles", STALL_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input coord_t want, input coord_t got);
		error_count++;
		if (error_count <= 10) begin
			$display("mismatch (%s): expected dim %0d %0d/%0d ovf %0b last %0b",
				what, want.dim, want.num, want.den, want.ovf, want.last);
			$display("  got dim %0d %0d/%0d ovf %0b last %0b",
				got.dim, got.num, got.den, got.ovf, got.last);
		end
	endtask

	// Result checker: compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		coord_t got;
		coord_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.dim  = m_tdata[2:0];
			got.num  = m_tdata[34:3];
			got.den  = m_tdata[66:35];
			got.ovf  = m_tuser[0];
			got.last = m_tlast;
			coords_checked++;
			if (coord_q.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = coord_q.pop_front();
				if (got.dim !== want.dim || got.num !== want.num || got.den !== want.den
						|| got.ovf !== want.ovf || got.last !== want.last)
					report_mismatch("field", want, got);
			end
		end
	end

	// One point of the radical-inverse sequence for one dimension
	task automatic advance_dimension(input int d);
		logic [63:0] p;
		logic [63:0] n;
		logic [63:0] dn;
		logic [63:0] x;
		logic [63:0] y;
		p  = 64'(PRIMES[d]);
		n  = 64'(frac_num[d]);
		dn = 64'(frac_den[d]);
		x  = dn - n;
		if (frac_stop[d])
			return;
		if (x == 64'd1) begin
			// next power of the prime, unless it no longer fits
			if (dn > FRAC_MAX / p) begin
				frac_stop[d] = 1'b1;
			end else begin
				frac_num[d] = 32'd1;
				frac_den[d] = 32'(dn * p);
			end
		end else begin
			y = dn / p;
			while (y != 0 && y >= x)
				y = y / p;
			frac_num[d] = 32'((p + 64'd1) * y - x);
		end
	endtask

	task automatic restart_fractions();
		for (int d = 0; d < MAX_REPORT; d++) begin
			frac_num[d]  = '0;
			frac_den[d]  = 32'd1;
			frac_stop[d] = 1'b0;
		end
	endtask

	// Expected coordinates for one accepted item
	task automatic predict_item(input logic rst, input logic [STEPS_W-1:0] steps);
		int     count;
		coord_t c;
		count = (active_cfg > MAX_REPORT) ? MAX_REPORT : int'(active_cfg);
		if (rst)
			restart_fractions();
		for (int s = 0; s < int'(steps); s++)
			for (int d = 0; d < count; d++)
				advance_dimension(d);
		for (int d = 0; d < count; d++) begin
			c.dim  = DIM_W'(d);
			c.num  = frac_num[d];
			c.den  = frac_den[d];
			c.ovf  = frac_stop[d];
			c.last = (d == count - 1);
			coord_q = {coord_q, c};
		end
	endtask

	// Send one item; valid stays high into the next item unless the sender idles
	task automatic send_item(input logic rst, input logic [STEPS_W-1:0] steps);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, steps, rst};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		predict_item(rst, steps);
	endtask

	// Wait until the block is idle and nothing is pending
	task automatic settle();
		s_tvalid <= 1'b0;
		while (coord_q.size() != 0)
			@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_active(input logic [ACTIVE_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		active_cfg = value;
		cfg_writes++;
	endtask

	// Default count of eight, zero steps, restart and the step extremes
	task automatic test_reset_state();
		send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd1);
		send_item(1'b0, 8'd255);
		send_item(1'b1, 8'd0);
		send_item(1'b1, 8'd1);
		send_item(1'b0, 8'd2);
	endtask

	// One active dimension; restart leaves the inactive ones cleared
	task automatic test_single_dimension();
		write_active(4'd1);
		send_item(1'b0, 8'd255);
		send_item(1'b1, 8'd255);
		send_item(1'b0, 8'd7);
	endtask

	// No active dimension: nothing advances, nothing comes out
	task automatic test_no_dimensions();
		write_active(4'd0);
		send_item(1'b0, 8'd5);
		send_item(1'b1, 8'd3);
	endtask

	// Counts above eight saturate, then a mid count
	task automatic test_saturated_count();
		write_active(4'd15);
		send_item(1'b0, 8'd4);
		send_item(1'b1, 8'd9);
		write_active(4'd9);
		send_item(1'b0, 8'd1);
		write_active(4'd3);
		send_item(1'b1, 8'd0);
		send_item(1'b0, 8'd128);
	endtask

	// Random items under one idle mix, count rewritten every dozen items
	task automatic test_random_mix(input int src_pct, input int sink_pct, input int n);
		int          r;
		logic [3:0]  cnt;
		logic [7:0]  steps;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 12 == 0) begin
				r = $urandom_range(99);
				if (r < 8)
					cnt = 4'($urandom_range(9, 15));
				else if (r < 12)
					cnt = 4'd0;
				else
					cnt = 4'($urandom_range(1, 8));
				write_active(cnt);
			end
			// mostly short runs, a few long ones
			if ($urandom_range(99) < 85)
				steps = 8'($urandom_range(0, 24));
			else
				steps = 8'($urandom_range(0, 255));
			send_item($urandom_range(7) == 0, steps);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		cfg_valid      <= 1'b0;
		cfg_data       <= '0;
		error_count    = 0;
		items_sent     = 0;
		coords_checked = 0;
		cfg_writes     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		active_cfg     = ACTIVE_RESET;
		restart_fractions();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_single_dimension();
		test_no_dimensions();
		test_saturated_count();
		test_random_mix(0, 0, 31);
		test_random_mix(52, 0, 31);
		test_random_mix(0, 52, 31);
		test_random_mix(11, 11, 31);

		// drain and let any trailing output show up
		s_tvalid <= 1'b0;
		while (coord_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("testbench: %0d items, %0d results checked, %0d count writes",
			items_sent, coords_checked, cfg_writes);
		$display("testbench: counts 0..15, zero/full steps, restarts, four idle mixes");
		if (coord_q.size() != 0) begin
			error_count++;
			$display("testbench: %0d expected results never arrived", coord_q.size());
		end
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: %0d mismatches", error_count);
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
